### sv/trrs_pkg.sv
// Shared types, constants and register codes for the timestamp rate rescaler.
package trrs_pkg;

  // Default timebase of the frame conversions, in ticks per second.
  localparam int unsigned TIME_SCALE_DEF = 1000000;

  // Field widths.
  localparam int CFG_W = 31;
  localparam int IDX_W = 2;
  localparam int VAL_W = 64;
  // Multiplier and divisor operands stay below 2^61 (31-bit register times a scale of 1e9).
  localparam int OPD_W = 61;
  localparam int DIV_STEPS = 64;

  // Conversion modes.
  typedef enum logic [1:0] {
    MODE_RESCALE = 2'd0,
    MODE_T2F     = 2'd1,
    MODE_F2T     = 2'd2
  } trrs_mode_t;

  // Configuration register indexes.
  localparam logic [IDX_W-1:0] REG_SCALE_FROM = 2'd0;
  localparam logic [IDX_W-1:0] REG_SCALE_TO   = 2'd1;
  localparam logic [IDX_W-1:0] REG_FPS_NUM    = 2'd2;
  localparam logic [IDX_W-1:0] REG_FPS_DEN    = 2'd3;

  // One classified item: the magnitude, its sign and the operands of the muldiv.
  typedef struct packed {
    logic              neg;
    logic [VAL_W-1:0]  mag;
    logic [OPD_W-1:0]  mul;
    logic [OPD_W-1:0]  div;
  } trrs_op_t;

endpackage

### sv/trrs_front.sv
// Front end: configuration registers, item intake and operand selection.
module trrs_front import trrs_pkg::*; #(
  parameter int unsigned TIME_SCALE = TIME_SCALE_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_wen,
  input  logic [IDX_W-1:0]        cfg_index,
  input  logic [CFG_W-1:0]        cfg_data,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [1:0]              mode,
  input  logic signed [VAL_W-1:0] value,
  output logic                    op_valid,
  input  logic                    op_ready,
  output trrs_op_t                op
);

  logic [CFG_W-1:0] scale_from;
  logic [CFG_W-1:0] scale_to;
  logic [CFG_W-1:0] fps_num;
  logic [OPD_W-1:0] den_ts;
  logic             f_valid;
  trrs_op_t         f_op;
  trrs_op_t         f_op_next;

  // Configuration registers; the frame rate denominator is kept only as its product
  // with the time scale.
  always_ff @(posedge clk) begin
    if (rst) begin
      scale_from <= CFG_W'(1000000);
      scale_to   <= CFG_W'(1000000);
      fps_num    <= CFG_W'(25);
      den_ts     <= OPD_W'(TIME_SCALE);
    end else if (cfg_wen) begin
      case (cfg_index)
        REG_SCALE_FROM: scale_from <= cfg_data;
        REG_SCALE_TO:   scale_to   <= cfg_data;
        REG_FPS_NUM:    fps_num    <= cfg_data;
        REG_FPS_DEN:    den_ts     <= OPD_W'(64'(cfg_data) * 64'(TIME_SCALE));
        default:        ;
      endcase
    end
  end

  // Classify the item. Equal scales pass through as a multiply and divide by one,
  // a zero divisor counts as one and the unused mode multiplies by zero.
  always_comb begin
    f_op_next.neg = value[VAL_W-1];
    f_op_next.mag = value[VAL_W-1] ? (VAL_W'(0) - VAL_W'(value)) : VAL_W'(value);
    f_op_next.mul = '0;
    f_op_next.div = OPD_W'(1);
    case (mode)
      MODE_RESCALE: begin
        if (scale_from != scale_to) begin
          f_op_next.mul = OPD_W'(scale_to);
          if (scale_from != '0) f_op_next.div = OPD_W'(scale_from);
        end else begin
          f_op_next.mul = OPD_W'(1);
        end
      end
      MODE_T2F: begin
        f_op_next.mul = OPD_W'(fps_num);
        if (den_ts != '0) f_op_next.div = den_ts;
      end
      MODE_F2T: begin
        f_op_next.mul = den_ts;
        if (fps_num != '0) f_op_next.div = OPD_W'(fps_num);
      end
      default: ;
    endcase
  end

  assign in_ready = !f_valid || op_ready;

  // Output register of the front end.
  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (in_ready) begin
      f_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      f_op <= f_op_next;
    end
  end

  assign op_valid = f_valid;
  assign op       = f_op;

endmodule

### sv/trrs_queue.sv
// Two-entry queue that decouples the front end from the arithmetic back end.
module trrs_queue import trrs_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     wr_valid,
  output logic     wr_ready,
  input  trrs_op_t wr_op,
  output logic     rd_valid,
  input  logic     rd_ready,
  output trrs_op_t rd_op
);

  trrs_op_t   mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign wr_ready = (count != 2'd2);
  assign rd_valid = (count != 2'd0);
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;
  assign rd_op    = mem[rd_ptr];

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= wr_op;
  end

endmodule

### sv/trrs_back.sv
// Back end: pipelined 64x61 multiply, one-bit-per-stage divider and saturation.
module trrs_back import trrs_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    op_valid,
  output logic                    op_ready,
  input  trrs_op_t                op,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [VAL_W-1:0] result,
  output logic                    overflow
);

  localparam logic [VAL_W-1:0] POS_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic [VAL_W-1:0] NEG_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  logic advance;

  // Multiply stage one: four 32x32 partial products.
  logic             m1_v;
  logic             m1_neg;
  logic [OPD_W-1:0] m1_div;
  logic [63:0]      p00, p01, p10, p11;
  logic [63:0]      b_ext;

  // Multiply stage two: the full product.
  logic             m2_v;
  logic             m2_neg;
  logic [OPD_W-1:0] m2_div;
  logic [127:0]     m2_prod;

  // Divider stages; entry 0 is loaded from the product.
  logic             dv_v   [DIV_STEPS+1];
  logic             dv_neg [DIV_STEPS+1];
  logic             dv_big [DIV_STEPS+1];
  logic [OPD_W-1:0] dv_d   [DIV_STEPS+1];
  logic [OPD_W-1:0] dv_rem [DIV_STEPS+1];
  logic [63:0]      dv_lo  [DIV_STEPS+1];
  logic [OPD_W-1:0] rem_next [DIV_STEPS];
  logic [63:0]      lo_next  [DIV_STEPS];

  // Output register.
  logic             o_v;
  logic [VAL_W-1:0] o_res;
  logic             o_ovf;
  logic [VAL_W-1:0] q;
  logic [VAL_W-1:0] res_next;
  logic             ovf_next;

  // The whole pipeline moves together unless a finished item waits at the output.
  assign advance  = !o_v || out_ready;
  assign op_ready = advance;
  assign b_ext    = 64'(op.mul);

  // Valid bits of all stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      m1_v <= 1'b0;
      m2_v <= 1'b0;
      o_v  <= 1'b0;
      for (int j = 0; j <= DIV_STEPS; j++) dv_v[j] <= 1'b0;
    end else if (advance) begin
      m1_v    <= op_valid;
      m2_v    <= m1_v;
      dv_v[0] <= m2_v;
      for (int j = 0; j < DIV_STEPS; j++) dv_v[j+1] <= dv_v[j];
      o_v <= dv_v[DIV_STEPS];
    end
  end

  // One restoring division step per stage: shift in the next product bit,
  // subtract where it fits and shift the quotient bit into the low word.
  always_comb begin
    logic [OPD_W:0] rs;
    logic           ge;
    for (int j = 0; j < DIV_STEPS; j++) begin
      rs          = {dv_rem[j], dv_lo[j][63]};
      ge          = (rs >= {1'b0, dv_d[j]});
      rem_next[j] = ge ? OPD_W'(rs - {1'b0, dv_d[j]}) : OPD_W'(rs);
      lo_next[j]  = {dv_lo[j][62:0], ge};
    end
  end

  // Sign and saturation of the quotient.
  assign q = dv_lo[DIV_STEPS];
  always_comb begin
    res_next = '0;
    ovf_next = 1'b0;
    if (dv_neg[DIV_STEPS]) begin
      if (dv_big[DIV_STEPS] || q > NEG_MIN) begin
        res_next = NEG_MIN;
        ovf_next = 1'b1;
      end else begin
        res_next = VAL_W'(0) - q;
      end
    end else begin
      if (dv_big[DIV_STEPS] || q > POS_MAX) begin
        res_next = POS_MAX;
        ovf_next = 1'b1;
      end else begin
        res_next = q;
      end
    end
  end

  // Payload of all stages.
  always_ff @(posedge clk) begin
    if (advance) begin
      m1_neg <= op.neg;
      m1_div <= op.div;
      p00    <= 64'(op.mag[31:0])  * 64'(b_ext[31:0]);
      p01    <= 64'(op.mag[31:0])  * 64'(b_ext[63:32]);
      p10    <= 64'(op.mag[63:32]) * 64'(b_ext[31:0]);
      p11    <= 64'(op.mag[63:32]) * 64'(b_ext[63:32]);

      m2_neg  <= m1_neg;
      m2_div  <= m1_div;
      m2_prod <= {p11, 64'd0} + {32'd0, p01, 32'd0} + {32'd0, p10, 32'd0}
                 + {64'd0, p00};

      // A high word at or above the divisor means a quotient of 2^64 or more.
      dv_neg[0] <= m2_neg;
      dv_d[0]   <= m2_div;
      dv_big[0] <= (m2_prod[127:64] >= 64'(m2_div));
      dv_rem[0] <= m2_prod[64+OPD_W-1:64];
      dv_lo[0]  <= m2_prod[63:0];
      for (int j = 0; j < DIV_STEPS; j++) begin
        dv_neg[j+1] <= dv_neg[j];
        dv_d[j+1]   <= dv_d[j];
        dv_big[j+1] <= dv_big[j];
        dv_rem[j+1] <= rem_next[j];
        dv_lo[j+1]  <= lo_next[j];
      end

      o_res <= res_next;
      o_ovf <= ovf_next;
    end
  end

  assign out_valid = o_v;
  assign result    = o_res;
  assign overflow  = o_ovf;

endmodule

### sv/timestamp_rate_rescaler_core.sv
// Top level of the timestamp rate rescaler: front end, queue and arithmetic back end.
//
//   Channel  Handshake              Payload
//   cfg      cfg_wen                cfg_index, cfg_data
//   in       in_valid / in_ready    mode, value
//   out      out_valid / out_ready  result, overflow
//
// One item is accepted per cycle and one result leaves per cycle when out_ready stays high.
// An accepted item passes the front-end register, the queue, the multiply stages,
// the 64-stage divider (one quotient bit per stage) and the output register; stalls hold it.
// Reset (rst, synchronous) empties every stage and restores the register defaults.
// A stalled output freezes the back end; the front end and queue keep taking up to three items.
module timestamp_rate_rescaler_core import trrs_pkg::*; #(
  parameter int unsigned TIME_SCALE = TIME_SCALE_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_wen,
  input  logic [IDX_W-1:0]        cfg_index,
  input  logic [CFG_W-1:0]        cfg_data,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [1:0]              mode,
  input  logic signed [VAL_W-1:0] value,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [VAL_W-1:0] result,
  output logic                    overflow
);

  logic     f_valid;
  logic     f_ready;
  trrs_op_t f_op;
  logic     b_valid;
  logic     b_ready;
  trrs_op_t b_op;

  trrs_front #(
    .TIME_SCALE(TIME_SCALE)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_wen  (cfg_wen),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .mode     (mode),
    .value    (value),
    .op_valid (f_valid),
    .op_ready (f_ready),
    .op       (f_op)
  );

  trrs_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_valid(f_valid),
    .wr_ready(f_ready),
    .wr_op   (f_op),
    .rd_valid(b_valid),
    .rd_ready(b_ready),
    .rd_op   (b_op)
  );

  trrs_back u_back (
    .clk      (clk),
    .rst      (rst),
    .op_valid (b_valid),
    .op_ready (b_ready),
    .op       (b_op),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .result   (result),
    .overflow (overflow)
  );

endmodule
